[rtl/srsw_pkg.sv]
// Shared types and constants of the selective-repeat sender window.
package srsw_pkg;

	localparam int SEQ_W   = 16;
	localparam int LEN_W   = 10;
	localparam int TMR_W   = 20;
	localparam int EVT_W   = 3;
	localparam int SLOT_W  = 4;
	localparam int OUTST_W = 5;
	localparam int CFG_W   = 20;
	localparam int CFGI_W  = 2;
	localparam int SUM_W   = SEQ_W + 1;

	localparam int WINDOW_DEF      = 16;
	localparam int MAX_PAYLOAD_DEF = 512;
	localparam int MAX_RESULTS     = 16;

	localparam logic [SEQ_W-1:0] START_SEQ_RST = '0;
	localparam logic [SEQ_W-1:0] SEQ_MOD_RST   = SEQ_W'(25601);
	localparam logic [TMR_W-1:0] TIMEOUT_RST   = TMR_W'(500000);

	typedef enum logic [1:0] {
		REQ_SEND = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_TICK = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [EVT_W-1:0] {
		EVT_SENT     = 3'd0,
		EVT_RESENT   = 3'd1,
		EVT_ACKED    = 3'd2,
		EVT_IGNORED  = 3'd3,
		EVT_FULL     = 3'd4,
		EVT_NONE_DUE = 3'd5
	} evt_t;

	typedef enum logic [CFGI_W-1:0] {
		CFG_START_SEQ = 2'd0,
		CFG_SEQ_MOD   = 2'd1,
		CFG_TIMEOUT   = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SEND_WAIT,
		S_ACK,
		S_ACK_WAIT,
		S_SLIDE,
		S_TICK,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic              start;
		logic [SEQ_W-1:0]  a;
		logic [LEN_W-1:0]  b;
	} madd_req_t;

	typedef struct packed {
		logic              done;
		logic [SEQ_W-1:0]  sum;
	} madd_rsp_t;

	typedef struct packed {
		evt_t              evt;
		logic [SEQ_W-1:0]  seq;
		logic [LEN_W-1:0]  len;
		logic [SLOT_W-1:0] slot;
	} res_t;

endpackage

[rtl/selective_repeat_sender_window_unit.sv]
// Top level of the selective-repeat sender window: sequencer, window state and beat registers.
// One request beat is taken at a time; in_stall stays high until its last result beat has
// been loaded into the output register. A send that finds room waits in S_SEND_WAIT for the
// sequence number sum, which the modular adder returns directly when it does not wrap and
// after a bit-serial reduction when it does. An ACK walks the window one slot at a time, and
// every unacked slot it visits runs its end number through the same modular adder; a match is
// followed by sliding out the acked head entries one by one until the head is found unacked.
// A tick visits one slot per cycle unless a resend waits on a stalled output register, and
// every last beat also waits for the output side. The modular adder is shared by sends and
// ACKs. There is no clearing pass after reset.
module selective_repeat_sender_window_unit
	import srsw_pkg::*;
#(
	parameter int WINDOW      = WINDOW_DEF,
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [LEN_W-1:0]   seg_length,
	input  logic [SEQ_W-1:0]   ack_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [EVT_W-1:0]   event_res,
	output logic [SEQ_W-1:0]   seq_number,
	output logic [LEN_W-1:0]   length_out,
	output logic [SLOT_W-1:0]  slot,
	output logic [OUTST_W-1:0] outstanding,
	output logic               last,
	input  logic               cfg_we,
	input  logic [CFGI_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);
	localparam int PAY_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int CMP_W  = (PAY_W > LEN_W) ? PAY_W : LEN_W;

	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(WINDOW)) begin
			s = s - (CNT_W+1)'(WINDOW);
		end
		return IDX_W'(s);
	endfunction

	// configuration
	logic [SEQ_W-1:0] seq_mod_q;
	logic [TMR_W-1:0] timeout_q;

	// window state
	logic [SEQ_W-1:0] entry_seq_q   [WINDOW];
	logic [LEN_W-1:0] entry_len_q   [WINDOW];
	logic [TMR_W-1:0] entry_timer_q [WINDOW];
	logic [WINDOW-1:0] acked_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;
	logic [SEQ_W-1:0] next_seq_q;

	// sequencer
	state_t            state_q;
	state_t            state_d;
	req_t              req_q;
	logic [LEN_W-1:0]  len_q;
	logic [SEQ_W-1:0]  ack_q;
	logic [CNT_W-1:0]  idx_q;
	logic [NRES_W-1:0] nres_q;
	res_t              pend_q;
	logic              pend_valid_q;

	// output beat register
	logic               out_valid_q;
	evt_t               out_evt_q;
	logic [SEQ_W-1:0]   out_seq_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [OUTST_W-1:0] out_outst_q;
	logic               out_last_q;

	logic             in_acc;
	logic [LEN_W-1:0] seg_len_sat;
	logic             full;
	logic [IDX_W-1:0] tail_slot;
	logic [IDX_W-1:0] scan_slot;
	logic [IDX_W-1:0] oldest_nxt;
	logic             scan_end;
	logic             cur_acked;
	logic [TMR_W-1:0] tmr_dec;
	logic             can_resend;
	logic             out_free;
	logic             tick_hold;
	logic             head_acked;
	logic             ack_match;
	logic             push;
	logic             push_last;
	res_t             push_res;
	madd_req_t        madd_req;
	madd_rsp_t        madd_rsp;

	srsw_modadd u_modadd (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (madd_req),
		.modulus (seq_mod_q),
		.rsp     (madd_rsp)
	);

	assign in_acc      = in_valid && !in_stall;
	assign seg_len_sat = (CMP_W'(seg_length) > CMP_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
	                                                                : seg_length;
	assign full        = (count_q == CNT_W'(WINDOW));
	assign tail_slot   = slot_add(oldest_q, count_q);
	assign scan_slot   = slot_add(oldest_q, idx_q);
	assign oldest_nxt  = (oldest_q == IDX_W'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
	assign scan_end    = (idx_q >= count_q);
	assign cur_acked   = acked_q[scan_slot];
	assign tmr_dec     = (entry_timer_q[scan_slot] == '0) ? '0
	                                                      : entry_timer_q[scan_slot] - 1'b1;
	assign can_resend  = (tmr_dec == '0) && (nres_q < NRES_W'(MAX_RESULTS));
	assign out_free    = !out_valid_q || !out_stall;
	assign tick_hold   = pend_valid_q && !out_free;
	assign head_acked  = (count_q != '0) && acked_q[oldest_q];
	assign ack_match   = (madd_rsp.sum == ack_q);
	assign push_res    = pend_valid_q ? pend_q : res_t'{EVT_NONE_DUE, '0, '0, '0};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_DECODE;
			end
			S_DECODE: begin
				unique case (req_q)
					REQ_SEND: state_d = full ? S_FLUSH : S_SEND_WAIT;
					REQ_ACK:  state_d = S_ACK;
					REQ_TICK: state_d = S_TICK;
					default:  state_d = S_FLUSH;
				endcase
			end
			S_SEND_WAIT: begin
				if (madd_rsp.done) state_d = S_FLUSH;
			end
			S_ACK: begin
				if (scan_end) state_d = S_FLUSH;
				else if (!cur_acked) state_d = S_ACK_WAIT;
			end
			S_ACK_WAIT: begin
				if (madd_rsp.done) state_d = ack_match ? S_SLIDE : S_ACK;
			end
			S_SLIDE: begin
				if (!head_acked) state_d = S_FLUSH;
			end
			S_TICK: begin
				if (scan_end) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall       = (state_q != S_IDLE);
		push           = 1'b0;
		push_last      = 1'b0;
		madd_req.start = 1'b0;
		madd_req.a     = entry_seq_q[scan_slot];
		madd_req.b     = entry_len_q[scan_slot];
		unique case (state_q)
			S_DECODE: begin
				madd_req.a     = next_seq_q;
				madd_req.b     = len_q;
				madd_req.start = (req_q == REQ_SEND) && !full;
			end
			S_ACK: begin
				madd_req.start = !scan_end && !cur_acked;
			end
			S_TICK: begin
				// a new resend pushes the previous one out, not as the last beat
				push = !scan_end && !cur_acked && can_resend && pend_valid_q && out_free;
			end
			S_FLUSH: begin
				push      = out_free;
				push_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_mod_q    <= SEQ_MOD_RST;
			timeout_q    <= TIMEOUT_RST;
			next_seq_q   <= START_SEQ_RST;
			acked_q      <= '0;
			oldest_q     <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			nres_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) pend_valid_q <= 1'b0;
				end
				S_DECODE: begin
					case (req_q)
						REQ_SEND: begin
							if (!full) begin
								acked_q[tail_slot] <= 1'b0;
								count_q            <= count_q + 1'b1;
							end
							pend_valid_q <= 1'b1;
						end
						REQ_ACK: idx_q <= '0;
						REQ_TICK: begin
							idx_q  <= '0;
							nres_q <= '0;
						end
						default: ;
					endcase
				end
				S_SEND_WAIT: begin
					if (madd_rsp.done) next_seq_q <= madd_rsp.sum;
				end
				S_ACK: begin
					if (scan_end) pend_valid_q <= 1'b1;
					else if (cur_acked) idx_q <= idx_q + 1'b1;
				end
				S_ACK_WAIT: begin
					if (madd_rsp.done) begin
						if (ack_match) begin
							acked_q[scan_slot] <= 1'b1;
							pend_valid_q       <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SLIDE: begin
					if (head_acked) begin
						acked_q[oldest_q] <= 1'b0;
						oldest_q          <= oldest_nxt;
						count_q           <= count_q - 1'b1;
					end
				end
				S_TICK: begin
					if (!scan_end) begin
						if (cur_acked || !can_resend) begin
							idx_q <= idx_q + 1'b1;
						end else if (!tick_hold) begin
							idx_q        <= idx_q + 1'b1;
							nres_q       <= nres_q + 1'b1;
							pend_valid_q <= 1'b1;
						end
					end
				end
				S_FLUSH: begin
					if (out_free) pend_valid_q <= 1'b0;
				end
				default: ;
			endcase

			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_START_SEQ: begin
						next_seq_q  <= cfg_data[SEQ_W-1:0];
					end
					CFG_SEQ_MOD: seq_mod_q <= cfg_data[SEQ_W-1:0];
					CFG_TIMEOUT: timeout_q <= cfg_data[TMR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			out_evt_q   <= push_res.evt;
			out_seq_q   <= push_res.seq;
			out_len_q   <= push_res.len;
			out_slot_q  <= push_res.slot;
			out_outst_q <= OUTST_W'(count_q);
			out_last_q  <= push_last;
		end

		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					req_q <= req_t'(req_type);
					len_q <= seg_len_sat;
					ack_q <= ack_number;
				end
			end
			S_DECODE: begin
				if (req_q == REQ_SEND) begin
					if (full) begin
						pend_q <= '{EVT_FULL, next_seq_q, len_q, '0};
					end else begin
						entry_seq_q[tail_slot]   <= next_seq_q;
						entry_len_q[tail_slot]   <= len_q;
						entry_timer_q[tail_slot] <= timeout_q;
						pend_q <= '{EVT_SENT, next_seq_q, len_q, SLOT_W'(tail_slot)};
					end
				end
			end
			S_ACK: begin
				if (scan_end) pend_q <= '{EVT_IGNORED, ack_q, '0, '0};
			end
			S_ACK_WAIT: begin
				if (madd_rsp.done && ack_match) begin
					pend_q <= '{EVT_ACKED, entry_seq_q[scan_slot], entry_len_q[scan_slot],
					            SLOT_W'(scan_slot)};
				end
			end
			S_TICK: begin
				if (!scan_end && !cur_acked) begin
					if (!can_resend) begin
						entry_timer_q[scan_slot] <= tmr_dec;
					end else if (!tick_hold) begin
						entry_timer_q[scan_slot] <= timeout_q;
						pend_q <= '{EVT_RESENT, entry_seq_q[scan_slot],
						            entry_len_q[scan_slot], SLOT_W'(scan_slot)};
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign event_res   = out_evt_q;
	assign seq_number  = out_seq_q;
	assign length_out  = out_len_q;
	assign slot        = out_slot_q;
	assign outstanding = out_outst_q;
	assign last        = out_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW))
		else $error("window count above window size");

	a_madd_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		madd_rsp.done |-> (state_q == S_SEND_WAIT || state_q == S_ACK_WAIT))
		else $error("modular sum finished outside a wait state");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_DECODE)
		else $error("accepted beat not decoded");

	a_resend_limit: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= NRES_W'(MAX_RESULTS))
		else $error("too many resends in one tick");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !push)
		else $error("stalled output beat overwritten");
`endif

endmodule

[rtl/srsw_modadd.sv]
// Shared modular adder: (a + b) mod modulus, restoring remainder one bit per cycle.
module srsw_modadd
	import srsw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  madd_req_t        req,
	input  logic [SEQ_W-1:0] modulus,
	output madd_rsp_t        rsp
);

	localparam int BIT_W = $clog2(SUM_W);

	logic [SUM_W-1:0] mod_ext;
	logic [SUM_W-1:0] sum;
	logic [SUM_W:0]   shifted;
	logic [SUM_W:0]   rem_nxt;
	logic             busy_q;
	logic             done_q;
	logic [BIT_W-1:0] cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] dvd_q;
	logic [SEQ_W-1:0] res_q;

	// modulus zero means the full 16-bit range
	assign mod_ext = (modulus == '0) ? {1'b1, {SEQ_W{1'b0}}} : SUM_W'(modulus);
	assign sum     = SUM_W'(req.a) + SUM_W'(req.b);
	assign shifted = {rem_q, dvd_q[SUM_W-1]};
	assign rem_nxt = (shifted >= {1'b0, mod_ext}) ? shifted - {1'b0, mod_ext} : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (sum < mod_ext) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= BIT_W'(SUM_W - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			res_q <= sum[SEQ_W-1:0];
			rem_q <= '0;
			dvd_q <= sum;
		end else if (busy_q) begin
			rem_q <= rem_nxt[SUM_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			if (cnt_q == '0) begin
				res_q <= rem_nxt[SEQ_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sum  = res_q;

endmodule

[sim/tb_selective_repeat_sender_window_unit.sv]
// Testbench for the selective-repeat sender window: beat-level predictor, scoreboard and stimulus.
module tb_selective_repeat_sender_window_unit;
	import srsw_pkg::*;

	localparam int QUIET_LIMIT = 5000;

	typedef struct {
		evt_t               evt;
		logic [SEQ_W-1:0]   seq;
		logic [LEN_W-1:0]   len;
		logic [SLOT_W-1:0]  slot;
		logic [OUTST_W-1:0] outst;
		logic               last;
	} beat_t;

	// Mirrors the window and holds the result beats still owed by the block.
	class window_scoreboard;
		logic [SEQ_W-1:0] reg_start;
		logic [SEQ_W-1:0] reg_mod;
		logic [TMR_W-1:0] reg_tmo;
		logic [SEQ_W-1:0] w_seq [WINDOW_DEF];
		logic [LEN_W-1:0] w_len [WINDOW_DEF];
		bit               w_acked [WINDOW_DEF];
		logic [TMR_W-1:0] w_tmr [WINDOW_DEF];
		int unsigned      head;
		int unsigned      count;
		logic [SEQ_W-1:0] next_seq;
		beat_t            due [$];
		int               errors;
		int               requests;
		int               beats;
		int               settings;
		int               tally [6];

		function new();
			reg_start = START_SEQ_RST;
			reg_mod = SEQ_MOD_RST;
			reg_tmo = TIMEOUT_RST;
			head = 0;
			count = 0;
			next_seq = START_SEQ_RST;
			errors = 0;
			requests = 0;
			beats = 0;
			settings = 0;
			foreach (w_acked[i]) w_acked[i] = 1'b0;
			foreach (tally[i]) tally[i] = 0;
		endfunction

		function logic [SEQ_W-1:0] seq_add(logic [SEQ_W-1:0] a, int unsigned b);
			int unsigned m;
			m = (reg_mod == 0) ? 65536 : reg_mod;
			return SEQ_W'((a + b) % m);
		endfunction

		function void load_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
			settings++;
			case (idx)
				CFG_START_SEQ: begin
					reg_start = v[SEQ_W-1:0];
					next_seq = v[SEQ_W-1:0];
				end
				CFG_SEQ_MOD: reg_mod = v[SEQ_W-1:0];
				CFG_TIMEOUT: reg_tmo = v[TMR_W-1:0];
				default: ;
			endcase
		endfunction

		function void add(evt_t e, logic [SEQ_W-1:0] sq, int unsigned ln, int unsigned sl);
			beat_t b;
			b.evt = e;
			b.seq = sq;
			b.len = LEN_W'(ln);
			b.slot = SLOT_W'(sl);
			b.outst = OUTST_W'(count);
			b.last = 1'b0;
			due.push_back(b);
		endfunction

		function int live_count();
			return count;
		endfunction

		function logic [SEQ_W-1:0] end_number(int k);
			int unsigned s;
			s = (head + k) % WINDOW_DEF;
			return seq_add(w_seq[s], w_len[s]);
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void note_request(logic [1:0] rq, logic [LEN_W-1:0] len_in,
				logic [SEQ_W-1:0] ack);
			int unsigned len;
			int unsigned s;
			int unsigned hit;
			int          n;
			bit          found;
			len = (len_in > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : len_in;
			requests++;
			n = 0;
			found = 1'b0;
			hit = 0;
			case (rq)
				REQ_SEND: begin
					if (count >= WINDOW_DEF) begin
						add(EVT_FULL, next_seq, len, 0);
					end else begin
						s = (head + count) % WINDOW_DEF;
						w_seq[s] = next_seq;
						w_len[s] = LEN_W'(len);
						w_acked[s] = 1'b0;
						w_tmr[s] = reg_tmo;
						count++;
						next_seq = seq_add(next_seq, len);
						add(EVT_SENT, w_seq[s], len, s);
					end
				end
				REQ_ACK: begin
					// oldest unacked entry whose end number matches wins
					for (int i = 0; i < count; i++) begin
						s = (head + i) % WINDOW_DEF;
						if (!found && !w_acked[s] && seq_add(w_seq[s], w_len[s]) == ack) begin
							found = 1'b1;
							hit = s;
						end
					end
					if (!found) begin
						add(EVT_IGNORED, ack, 0, 0);
					end else begin
						w_acked[hit] = 1'b1;
						while (count > 0 && w_acked[head]) begin
							w_acked[head] = 1'b0;
							head = (head + 1) % WINDOW_DEF;
							count--;
						end
						add(EVT_ACKED, w_seq[hit], w_len[hit], hit);
					end
				end
				REQ_TICK: begin
					for (int i = 0; i < count; i++) begin
						s = (head + i) % WINDOW_DEF;
						if (!w_acked[s]) begin
							if (w_tmr[s] > 0) w_tmr[s]--;
							if (w_tmr[s] == 0 && n < MAX_RESULTS) begin
								w_tmr[s] = reg_tmo;
								add(EVT_RESENT, w_seq[s], w_len[s], s);
								n++;
							end
						end
					end
					if (n == 0) add(EVT_NONE_DUE, '0, 0, 0);
				end
				default: add(EVT_NONE_DUE, '0, 0, 0);
			endcase
			due[due.size()-1].last = 1'b1;
		endfunction

		function void check_result(logic [EVT_W-1:0] ev, logic [SEQ_W-1:0] sq,
				logic [LEN_W-1:0] ln, logic [SLOT_W-1:0] sl, logic [OUTST_W-1:0] os, logic lt);
			beat_t w;
			beats++;
			if (due.size() == 0) begin
				$error("result beat with nothing expected: event_res %0d seq_number %0d", ev, sq);
				errors++;
				return;
			end
			w = due.pop_front();
			tally[w.evt]++;
			if (ev !== w.evt) begin
				$error("event_res: expected %0d, got %0d", w.evt, ev);
				errors++;
			end
			if (sq !== w.seq) begin
				$error("seq_number: expected %0d, got %0d", w.seq, sq);
				errors++;
			end
			if (ln !== w.len) begin
				$error("length_out: expected %0d, got %0d", w.len, ln);
				errors++;
			end
			if (sl !== w.slot) begin
				$error("slot: expected %0d, got %0d", w.slot, sl);
				errors++;
			end
			if (os !== w.outst) begin
				$error("outstanding: expected %0d, got %0d", w.outst, os);
				errors++;
			end
			if (lt !== w.last) begin
				$error("last: expected %0d, got %0d", w.last, lt);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type = REQ_NONE;
	logic [LEN_W-1:0]   seg_length = '0;
	logic [SEQ_W-1:0]   ack_number = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [EVT_W-1:0]   event_res;
	logic [SEQ_W-1:0]   seq_number;
	logic [LEN_W-1:0]   length_out;
	logic [SLOT_W-1:0]  slot;
	logic [OUTST_W-1:0] outstanding;
	logic               last;
	logic               cfg_we = 1'b0;
	logic [CFGI_W-1:0]  cfg_index = CFG_START_SEQ;
	logic [CFG_W-1:0]   cfg_data = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int quiet = 0;

	window_scoreboard sb = new();

	selective_repeat_sender_window_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.seg_length  (seg_length),
		.ack_number  (ack_number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.seq_number  (seq_number),
		.length_out  (length_out),
		.slot        (slot),
		.outstanding (outstanding),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(event_res, seq_number, length_out, slot, outstanding, last);
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid && out_stall === 1'b0)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("selective_repeat_sender_window_unit regression: fail");
				$finish;
			end
		end
	end

	task automatic push_request(logic [1:0] rq, logic [LEN_W-1:0] ln, logic [SEQ_W-1:0] ak);
		int gap;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		seg_length <= ln;
		ack_number <= ak;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		sb.note_request(rq, ln, ak);
	endtask

	task automatic program_regs(logic [SEQ_W-1:0] st, logic [SEQ_W-1:0] md, logic [TMR_W-1:0] tm);
		cfg_we <= 1'b1;
		cfg_index <= CFG_START_SEQ;
		cfg_data <= CFG_W'(st);
		@(posedge clk);
		sb.load_reg(CFG_START_SEQ, CFG_W'(st));
		cfg_index <= CFG_SEQ_MOD;
		cfg_data <= CFG_W'(md);
		@(posedge clk);
		sb.load_reg(CFG_SEQ_MOD, CFG_W'(md));
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= CFG_W'(tm);
		@(posedge clk);
		sb.load_reg(CFG_TIMEOUT, CFG_W'(tm));
		cfg_we <= 1'b0;
	endtask

	// stop offering, wait for every owed beat, then let the sequencer settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_request();
		int               pick;
		int               k;
		logic [LEN_W-1:0] ln;
		pick = $urandom_range(99);
		ln = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(1023))
			: LEN_W'($urandom_range(MAX_PAYLOAD_DEF));
		if (sb.live_count() != 0 && pick < 40) begin
			// selective ack: any entry in the window, out of order
			k = $urandom_range(sb.live_count() - 1);
			push_request(REQ_ACK, LEN_W'($urandom), sb.end_number(k));
		end else if (pick < 70) begin
			push_request(REQ_SEND, ln, SEQ_W'($urandom));
		end else if (pick < 90) begin
			push_request(REQ_TICK, LEN_W'($urandom), SEQ_W'($urandom));
		end else if (pick < 95) begin
			push_request(REQ_ACK, LEN_W'($urandom), SEQ_W'($urandom));
		end else begin
			push_request(REQ_NONE, LEN_W'($urandom), SEQ_W'($urandom));
		end
	endtask

	task automatic run_phase(int n, int ip, int sp);
		idle_pct = ip;
		stall_pct = sp;
		repeat (n) random_request();
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// reset values: empty tick, unknown request, one send and its ack
		push_request(REQ_TICK, '0, '0);
		push_request(REQ_NONE, 10'h3FF, 16'hFFFF);
		push_request(REQ_SEND, 10'd100, '0);
		push_request(REQ_ACK, '0, sb.end_number(0));
		drain();

		// modulus zero wraps at 16 bits, timeout zero resends every tick
		program_regs(16'hFFFF, 16'h0000, '0);
		push_request(REQ_SEND, 10'h3FF, 16'hFFFF);
		push_request(REQ_SEND, 10'd0, '0);
		push_request(REQ_SEND, 10'd513, '0);
		push_request(REQ_ACK, '0, 16'hFFFF);
		push_request(REQ_TICK, '0, '0);
		push_request(REQ_ACK, '0, sb.end_number(2));
		push_request(REQ_ACK, '0, sb.end_number(0));
		drain();

		// start above modulus, then fill the window and overflow it
		program_regs(16'd60000, 16'd1000, 20'd1);
		while (sb.live_count() < WINDOW_DEF)
			push_request(REQ_SEND, LEN_W'($urandom_range(MAX_PAYLOAD_DEF)), '0);
		push_request(REQ_SEND, 10'd512, '0);
		push_request(REQ_TICK, '0, '0);
		drain();

		// long receiver hold-off while the sender keeps offering
		program_regs('0, 16'hFFFF, 20'd3);
		hold_request = 400;
		run_phase(45, 0, 0);

		program_regs(16'd1234, 16'd1, 20'hFFFFF);
		run_phase(40, 86, 0);

		program_regs(SEQ_W'($urandom), SEQ_W'($urandom_range(5000, 300)), 20'd2);
		run_phase(45, 0, 86);

		program_regs(SEQ_W'($urandom), SEQ_MOD_RST, '0);
		run_phase(45, 22, 22);

		$display("covered %0d requests, %0d result beats, %0d register writes",
			sb.requests, sb.beats, sb.settings);
		$display("beats: sent %0d, resent %0d, acked %0d, ignored %0d, full %0d, nothing due %0d",
			sb.tally[EVT_SENT], sb.tally[EVT_RESENT], sb.tally[EVT_ACKED],
			sb.tally[EVT_IGNORED], sb.tally[EVT_FULL], sb.tally[EVT_NONE_DUE]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("selective_repeat_sender_window_unit regression: pass");
		end else begin
			$display("selective_repeat_sender_window_unit regression: fail");
		end
		$finish;
	end

endmodule
